// ===== sv/ffpa_pkg.sv =====
// ffpa_pkg: shared types, codes and constants of the first-fit pool allocator
// used by ffpa_ctrl, ffpa_dp and first_fit_pool_allocator_top; no dependencies
package ffpa_pkg;

  localparam int PageBytes    = 4096;
  localparam int MaxPoolPages = 256;
  localparam int MaxSegments  = 32;

  localparam int AddrW  = 20;
  localparam int LenW   = 21;
  localparam int PagesW = 9;
  localparam int CmdW   = 2;
  localparam int StatW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_INIT    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_NO_FIT     = 3'd2,
    ST_BAD_ADDR   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_ZERO_SIZE  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_CLEAR,
    DP_INIT,
    DP_FIT,
    DP_ALLOC,
    DP_USED,
    DP_MERGE,
    DP_FMERGE,
    DP_REM_HI,
    DP_REM_LO,
    DP_PUSH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIT,
    S_ALLOC,
    S_USED,
    S_MERGE,
    S_FCHK,
    S_REM_HI,
    S_REM_LO,
    S_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic pool_ready;
    logic size_zero;
    logic cur_free_valid;
    logic idx_last;
    logic fit_hit;
    logic used_hit;
    logic slot_found;
    logic full_nomerge;
  } dp_stat_t;

endpackage

// ===== sv/ffpa_dp.sv =====
// ffpa_dp: free list, reserved table, scan index and merge registers
// depends on ffpa_pkg; driven by ffpa_ctrl through dp_cmd_t / dp_stat_t
module ffpa_dp #(
  parameter int MAX_SEGMENTS = ffpa_pkg::MaxSegments
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffpa_pkg::PagesW-1:0]   cfg_wdata_i,
  input  logic [ffpa_pkg::LenW-1:0]     size_i,
  input  logic [ffpa_pkg::AddrW-1:0]    off_i,
  input  ffpa_pkg::dp_cmd_t             cmd_i,
  output ffpa_pkg::dp_stat_t            stat_o,
  output logic [ffpa_pkg::AddrW-1:0]    granted_o
);

  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int AW   = ffpa_pkg::AddrW;
  localparam int LW   = ffpa_pkg::LenW;
  localparam int EW   = ffpa_pkg::LenW + 1;

  logic [AW-1:0] fbase_q [MAX_SEGMENTS];
  logic [AW-1:0] fbase_d [MAX_SEGMENTS];
  logic [LW-1:0] flen_q  [MAX_SEGMENTS];
  logic [LW-1:0] flen_d  [MAX_SEGMENTS];
  logic [AW-1:0] ubase_q [MAX_SEGMENTS];
  logic [AW-1:0] ubase_d [MAX_SEGMENTS];
  logic [LW-1:0] ulen_q  [MAX_SEGMENTS];
  logic [LW-1:0] ulen_d  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] fvalid_q, fvalid_d, uvalid_q, uvalid_d;

  logic                    ready_q, ready_d;
  logic [ffpa_pkg::PagesW-1:0] pages_q;
  logic [IdxW-1:0]         idx_q, idx_d, k_q, k_d;
  logic [IdxW-1:0]         front_q, front_d, back_q, back_d;
  logic                    ff_q, ff_d, bf_q, bf_d;
  logic [LW-1:0]           front_len_q, front_len_d, back_len_q, back_len_d;
  logic [AW-1:0]           back_base_q, back_base_d;
  logic [LW-1:0]           size_q, size_d, m_len_q, m_len_d;
  logic [AW-1:0]           off_q, off_d, m_base_q, m_base_d, granted_q, granted_d;

  logic [AW-1:0]   cur_fbase;
  logic [LW-1:0]   cur_flen;
  logic [EW-1:0]   cur_end, m_end;
  logic [IdxW-1:0] slot;
  logic            rem_en, push_en;
  logic [IdxW-1:0] rem_idx;
  logic [LW-1:0]   init_len;

  assign cur_fbase = fbase_q[idx_q];
  assign cur_flen  = flen_q[idx_q];
  assign cur_end   = EW'(cur_fbase) + EW'(cur_flen);
  assign m_end     = EW'(m_base_q) + EW'(m_len_q);

  // first free slot of the reserved table
  always_comb begin
    slot = '0;
    for (int j = MAX_SEGMENTS - 1; j >= 0; j--) begin
      if (!uvalid_q[j]) slot = IdxW'(j);
    end
  end

  always_comb begin
    int unsigned pg;
    pg = int'(pages_q);
    if (pg == 0) pg = 1;
    if (pg > ffpa_pkg::MaxPoolPages) pg = ffpa_pkg::MaxPoolPages;
    init_len = LW'(pg * ffpa_pkg::PageBytes);
  end

  assign stat_o.pool_ready     = ready_q;
  assign stat_o.size_zero      = (size_q == '0);
  assign stat_o.cur_free_valid = fvalid_q[idx_q];
  assign stat_o.idx_last       = (idx_q == IdxW'(MAX_SEGMENTS - 1));
  assign stat_o.fit_hit        = (cur_flen >= size_q);
  assign stat_o.used_hit       = uvalid_q[idx_q] && (ubase_q[idx_q] == off_q);
  assign stat_o.slot_found     = ~&uvalid_q;
  assign stat_o.full_nomerge   = fvalid_q[MAX_SEGMENTS-1] && !ff_q && !bf_q;
  assign granted_o             = granted_q;

  always_comb begin
    fbase_d = fbase_q; flen_d = flen_q; fvalid_d = fvalid_q;
    ubase_d = ubase_q; ulen_d = ulen_q; uvalid_d = uvalid_q;
    ready_d = ready_q; idx_d = idx_q; k_d = k_q;
    front_d = front_q; back_d = back_q; ff_d = ff_q; bf_d = bf_q;
    front_len_d = front_len_q; back_len_d = back_len_q; back_base_d = back_base_q;
    size_d = size_q; off_d = off_q; m_len_d = m_len_q; m_base_d = m_base_q;
    granted_d = granted_q;
    rem_en = 1'b0; rem_idx = idx_q; push_en = 1'b0;
    unique case (cmd_i.op)
      ffpa_pkg::DP_NONE: ;
      ffpa_pkg::DP_LATCH: begin
        size_d = size_i; off_d = off_i; idx_d = '0;
        ff_d = 1'b0; bf_d = 1'b0; granted_d = '0;
      end
      ffpa_pkg::DP_CLEAR: begin
        fvalid_d = '0; uvalid_d = '0; ready_d = 1'b0;
      end
      ffpa_pkg::DP_INIT: begin
        fvalid_d = '0; uvalid_d = '0; ready_d = 1'b1;
        fvalid_d[0] = 1'b1; fbase_d[0] = '0; flen_d[0] = init_len;
      end
      ffpa_pkg::DP_FIT: begin
        if (!stat_o.fit_hit) idx_d = idx_q + 1'b1;
      end
      ffpa_pkg::DP_ALLOC: begin
        uvalid_d[slot] = 1'b1; ubase_d[slot] = cur_fbase; ulen_d[slot] = size_q;
        granted_d = cur_fbase;
        if (cur_flen == size_q) begin
          rem_en = 1'b1;
        end else begin
          flen_d[idx_q]  = cur_flen - size_q;
          fbase_d[idx_q] = cur_fbase + AW'(size_q);
        end
      end
      ffpa_pkg::DP_USED: begin
        if (stat_o.used_hit) begin
          k_d = idx_q; m_base_d = ubase_q[idx_q]; m_len_d = ulen_q[idx_q]; idx_d = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ffpa_pkg::DP_MERGE: begin
        if (fvalid_q[idx_q]) begin
          if (!ff_q && EW'(cur_fbase) == m_end) begin
            ff_d = 1'b1; front_d = idx_q; front_len_d = cur_flen;
          end else if (!bf_q && cur_end == EW'(m_base_q)) begin
            bf_d = 1'b1; back_d = idx_q; back_len_d = cur_flen; back_base_d = cur_fbase;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ffpa_pkg::DP_FMERGE: begin
        uvalid_d[k_q] = 1'b0;
        m_len_d = m_len_q + (ff_q ? front_len_q : '0) + (bf_q ? back_len_q : '0);
        if (bf_q) m_base_d = back_base_q;
      end
      ffpa_pkg::DP_REM_HI: begin
        rem_en  = ff_q || bf_q;
        rem_idx = (ff_q && bf_q) ? ((front_q > back_q) ? front_q : back_q)
                                 : (ff_q ? front_q : back_q);
      end
      ffpa_pkg::DP_REM_LO: begin
        rem_en  = ff_q && bf_q;
        rem_idx = (front_q > back_q) ? back_q : front_q;
      end
      ffpa_pkg::DP_PUSH: push_en = 1'b1;
      default: ;
    endcase
    // unlink: entries behind rem_idx move up one place
    if (rem_en) begin
      for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
        if (j >= int'(rem_idx)) begin
          fbase_d[j] = fbase_q[j+1]; flen_d[j] = flen_q[j+1]; fvalid_d[j] = fvalid_q[j+1];
        end
      end
      fvalid_d[MAX_SEGMENTS-1] = 1'b0;
    end
    if (push_en) begin
      for (int j = MAX_SEGMENTS - 1; j > 0; j--) begin
        fbase_d[j] = fbase_q[j-1]; flen_d[j] = flen_q[j-1]; fvalid_d[j] = fvalid_q[j-1];
      end
      fbase_d[0] = m_base_q; flen_d[0] = m_len_q; fvalid_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
      uvalid_q <= '0;
      ready_q  <= 1'b0;
      pages_q  <= ffpa_pkg::PagesW'(1);
      idx_q    <= '0;
      ff_q     <= 1'b0;
      bf_q     <= 1'b0;
    end else begin
      fvalid_q <= fvalid_d;
      uvalid_q <= uvalid_d;
      ready_q  <= ready_d;
      if (cfg_we_i) pages_q <= cfg_wdata_i;
      idx_q    <= idx_d;
      ff_q     <= ff_d;
      bf_q     <= bf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fbase_q <= fbase_d; flen_q <= flen_d; ubase_q <= ubase_d; ulen_q <= ulen_d;
    k_q <= k_d; front_q <= front_d; back_q <= back_d;
    front_len_q <= front_len_d; back_len_q <= back_len_d; back_base_q <= back_base_d;
    size_q <= size_d; off_q <= off_d; m_len_q <= m_len_d; m_base_q <= m_base_d;
    granted_q <= granted_d;
  end

  // free list entries stay a prefix in list order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fvalid_q >> 1) & ~fvalid_q) == '0)
    else $error("free list has a hole");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ffpa_pkg::DP_CLEAR) |=> (!ready_q && fvalid_q == '0 && uvalid_q == '0))
    else $error("release left state behind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ffpa_pkg::DP_ALLOC) |=>
      ($countones(uvalid_q) == $countones($past(uvalid_q)) + 1))
    else $error("alloc did not add one reserved segment");

endmodule

// ===== sv/ffpa_ctrl.sv =====
// ffpa_ctrl: command sequencer of the pool allocator
// depends on ffpa_pkg; steers ffpa_dp and hands the status to the output register
module ffpa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ffpa_pkg::CmdW-1:0]    cmd_i,
  input  logic                         out_free_i,
  output logic                         res_load_o,
  output ffpa_pkg::status_e            status_o,
  input  ffpa_pkg::dp_stat_t           stat_i,
  output ffpa_pkg::dp_cmd_t            dp_cmd_o
);

  ffpa_pkg::state_e  state_q, state_d;
  ffpa_pkg::cmd_e    cmd_q;
  ffpa_pkg::status_e st_q, st_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      ffpa_pkg::S_IDLE: if (in_valid_i) state_d = ffpa_pkg::S_DISPATCH;
      ffpa_pkg::S_DISPATCH: begin
        st_d    = ffpa_pkg::ST_OK;
        state_d = ffpa_pkg::S_DONE;
        unique case (cmd_q)
          ffpa_pkg::CMD_ALLOC: begin
            if (!stat_i.pool_ready) st_d = ffpa_pkg::ST_NOT_READY;
            else if (stat_i.size_zero) st_d = ffpa_pkg::ST_ZERO_SIZE;
            else state_d = ffpa_pkg::S_FIT;
          end
          ffpa_pkg::CMD_FREE: begin
            if (!stat_i.pool_ready) st_d = ffpa_pkg::ST_NOT_READY;
            else state_d = ffpa_pkg::S_USED;
          end
          ffpa_pkg::CMD_INIT, ffpa_pkg::CMD_RELEASE: ;
          default: ;
        endcase
      end
      ffpa_pkg::S_FIT: begin
        if (!stat_i.cur_free_valid) begin
          st_d = ffpa_pkg::ST_NO_FIT; state_d = ffpa_pkg::S_DONE;
        end else if (stat_i.fit_hit) begin
          if (stat_i.slot_found) begin
            state_d = ffpa_pkg::S_ALLOC;
          end else begin
            st_d = ffpa_pkg::ST_TABLE_FULL; state_d = ffpa_pkg::S_DONE;
          end
        end else if (stat_i.idx_last) begin
          st_d = ffpa_pkg::ST_NO_FIT; state_d = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_ALLOC: state_d = ffpa_pkg::S_DONE;
      ffpa_pkg::S_USED: begin
        if (stat_i.used_hit) begin
          state_d = ffpa_pkg::S_MERGE;
        end else if (stat_i.idx_last) begin
          st_d = ffpa_pkg::ST_BAD_ADDR; state_d = ffpa_pkg::S_DONE;
        end
      end
      ffpa_pkg::S_MERGE: begin
        if (!stat_i.cur_free_valid || stat_i.idx_last) state_d = ffpa_pkg::S_FCHK;
      end
      ffpa_pkg::S_FCHK: begin
        if (stat_i.full_nomerge) begin
          st_d = ffpa_pkg::ST_TABLE_FULL; state_d = ffpa_pkg::S_DONE;
        end else begin
          state_d = ffpa_pkg::S_REM_HI;
        end
      end
      ffpa_pkg::S_REM_HI: state_d = ffpa_pkg::S_REM_LO;
      ffpa_pkg::S_REM_LO: state_d = ffpa_pkg::S_PUSH;
      ffpa_pkg::S_PUSH:   state_d = ffpa_pkg::S_DONE;
      ffpa_pkg::S_DONE:   if (out_free_i) state_d = ffpa_pkg::S_IDLE;
      default:            state_d = ffpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_load_o  = 1'b0;
    dp_cmd_o.op = ffpa_pkg::DP_NONE;
    unique case (state_q)
      ffpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) dp_cmd_o.op = ffpa_pkg::DP_LATCH;
      end
      ffpa_pkg::S_DISPATCH: begin
        if (cmd_q == ffpa_pkg::CMD_INIT && !stat_i.pool_ready) dp_cmd_o.op = ffpa_pkg::DP_INIT;
        if (cmd_q == ffpa_pkg::CMD_RELEASE) dp_cmd_o.op = ffpa_pkg::DP_CLEAR;
      end
      ffpa_pkg::S_FIT:    dp_cmd_o.op = ffpa_pkg::DP_FIT;
      ffpa_pkg::S_ALLOC:  dp_cmd_o.op = ffpa_pkg::DP_ALLOC;
      ffpa_pkg::S_USED:   dp_cmd_o.op = ffpa_pkg::DP_USED;
      ffpa_pkg::S_MERGE:  dp_cmd_o.op = ffpa_pkg::DP_MERGE;
      ffpa_pkg::S_FCHK:   if (!stat_i.full_nomerge) dp_cmd_o.op = ffpa_pkg::DP_FMERGE;
      ffpa_pkg::S_REM_HI: dp_cmd_o.op = ffpa_pkg::DP_REM_HI;
      ffpa_pkg::S_REM_LO: dp_cmd_o.op = ffpa_pkg::DP_REM_LO;
      ffpa_pkg::S_PUSH:   dp_cmd_o.op = ffpa_pkg::DP_PUSH;
      ffpa_pkg::S_DONE:   res_load_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffpa_pkg::S_IDLE;
      st_q    <= ffpa_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) cmd_q <= ffpa_pkg::cmd_e'(cmd_i);
  end

  assign status_o = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::S_IDLE && in_valid_i) |=> (state_q == ffpa_pkg::S_DISPATCH))
    else $error("accepted item not dispatched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> (state_q == ffpa_pkg::S_DONE))
    else $error("result loaded outside done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpa_pkg::S_ALLOC) |-> (st_q == ffpa_pkg::ST_OK))
    else $error("commit with error status");

endmodule

// ===== sv/first_fit_pool_allocator_top.sv =====
// first_fit_pool_allocator_top: first-fit pool allocator with free-segment coalescing
// depends on ffpa_pkg, ffpa_ctrl, ffpa_dp
//
//  port group   dir  payload
//  s_axis_*     in   tuser: command[1:0]; tdata: request_size[20:0], block_offset[40:21]
//  m_axis_*     out  tuser: status[2:0]; tdata: granted_offset[19:0]
//  cfg_*        in   cfg_wdata_i: pool_pages[8:0]
//
// the scans go one entry per cycle; init, release and commands rejected at dispatch
// skip them; alloc scans the free list for the first fitting segment, then commits;
// free scans the reserved table for the offset, then the free list for neighbours,
// unlinks them and pushes the merged segment, or scans the whole reserved table for an
// unknown offset; reset empties both lists at once via valid bits; no clearing pass
// a waiting result sits in the output register; the sequencer holds in its last step
// until that register is free
module first_fit_pool_allocator_top #(
  parameter int MAX_SEGMENTS = ffpa_pkg::MaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // request_size[20:0], block_offset[40:21]
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // granted_offset[19:0]
  output logic [2:0]  m_axis_tuser_o,   // status[2:0]
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  ffpa_pkg::dp_cmd_t  dp_cmd;
  ffpa_pkg::dp_stat_t dp_stat;
  ffpa_pkg::status_e  status;
  logic [ffpa_pkg::AddrW-1:0] granted;
  logic res_load, out_free;

  logic                       m_valid_q;
  logic [ffpa_pkg::StatW-1:0] m_status_q;
  logic [ffpa_pkg::AddrW-1:0] m_granted_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .status_o   (status),
    .stat_i     (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  ffpa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .size_i      (s_axis_tdata_i[20:0]),
    .off_i       (s_axis_tdata_i[40:21]),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .granted_o   (granted)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_status_q  <= status;
      m_granted_q <= granted;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {4'b0, m_granted_q};

endmodule

// ===== tb/tb.sv =====
// tb: stream-level testbench for first_fit_pool_allocator_top
// depends on ffpa_pkg and the allocator rtl; self-checking against an in-bench pool predictor
`timescale 1ns / 100ps

module tb;
  import ffpa_pkg::*;

  localparam int NSeg = MaxSegments;
  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;

  first_fit_pool_allocator_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    status_e     status;
    logic [19:0] granted;
  } grant_t;

  typedef struct {
    cmd_e        cmd;
    logic [20:0] size;
    logic [19:0] offset;
    logic        has_want;
    grant_t      want;
  } stim_t;

  // predictor state
  logic [8:0]  pages_reg;
  logic        ready_q;
  logic [19:0] fbase [NSeg];
  logic [20:0] flen  [NSeg];
  logic        fval  [NSeg];
  logic [19:0] ubase [NSeg];
  logic [20:0] ulen  [NSeg];
  logic        uval  [NSeg];

  grant_t grant_q[$];
  logic [19:0] live_q[$];   // offsets currently reserved, for well-formed frees
  int errors = 0;
  int cycles = 0;
  int stall_cnt = 0;

  function automatic void clear_pool();
    for (int i = 0; i < NSeg; i++) begin
      fval[i] = 0; uval[i] = 0; fbase[i] = 0; flen[i] = 0; ubase[i] = 0; ulen[i] = 0;
    end
  endfunction

  function automatic int free_len_count();
    int n;
    n = 0;
    while (n < NSeg && fval[n]) n++;
    return n;
  endfunction

  function automatic void unlink_free(int idx);
    if (idx < 0) return;
    for (int j = idx; j + 1 < NSeg; j++) begin
      fbase[j] = fbase[j+1]; flen[j] = flen[j+1]; fval[j] = fval[j+1];
    end
    fbase[NSeg-1] = 0; flen[NSeg-1] = 0; fval[NSeg-1] = 0;
  endfunction

  function automatic grant_t pool_step(cmd_e cmd, logic [20:0] size, logic [19:0] off);
    grant_t r;
    int n, fit, slot, k, front, back, cnt, pg;
    logic [20:0] base, len, e;
    r.status = ST_OK; r.granted = '0;
    case (cmd)
      CMD_ALLOC: begin
        fit = -1; slot = -1;
        if (!ready_q) r.status = ST_NOT_READY;
        else if (size == 0) r.status = ST_ZERO_SIZE;
        else begin
          n = free_len_count();
          for (int i = 0; i < n; i++) if (fit < 0 && flen[i] >= size) fit = i;
          for (int i = 0; i < NSeg; i++) if (slot < 0 && !uval[i]) slot = i;
          if (fit < 0) r.status = ST_NO_FIT;
          else if (slot < 0) r.status = ST_TABLE_FULL;
          else begin
            ubase[slot] = fbase[fit]; ulen[slot] = size; uval[slot] = 1;
            r.granted = fbase[fit];
            if (flen[fit] == size) unlink_free(fit);
            else begin
              flen[fit] -= size; fbase[fit] += size[19:0];
            end
          end
        end
      end
      CMD_FREE: begin
        k = -1; front = -1; back = -1;
        if (!ready_q) r.status = ST_NOT_READY;
        else begin
          for (int i = 0; i < NSeg; i++) if (k < 0 && uval[i] && ubase[i] == off) k = i;
          if (k < 0) r.status = ST_BAD_ADDR;
          else begin
            base = {1'b0, ubase[k]}; len = ulen[k]; e = base + len;
            n = free_len_count();
            for (int i = 0; i < n; i++) begin
              if (front < 0 && {1'b0, fbase[i]} == e) front = i;
              else if (back < 0 && {1'b0, fbase[i]} + flen[i] == base) back = i;
            end
            cnt = n + 1 - (front >= 0) - (back >= 0);
            if (cnt > NSeg) r.status = ST_TABLE_FULL;
            else begin
              uval[k] = 0; ubase[k] = 0; ulen[k] = 0;
              if (front >= 0) len += flen[front];
              if (back >= 0) begin
                len += flen[back]; base = {1'b0, fbase[back]};
              end
              if (front > back) begin
                unlink_free(front); unlink_free(back);
              end else begin
                unlink_free(back); unlink_free(front);
              end
              for (int j = NSeg - 1; j > 0; j--) begin
                fbase[j] = fbase[j-1]; flen[j] = flen[j-1]; fval[j] = fval[j-1];
              end
              fbase[0] = base[19:0]; flen[0] = len; fval[0] = 1;
            end
          end
        end
      end
      CMD_INIT: begin
        if (!ready_q) begin
          pg = pages_reg;
          if (pg == 0) pg = 1;
          if (pg > MaxPoolPages) pg = MaxPoolPages;
          clear_pool();
          fbase[0] = 0; flen[0] = 21'(pg * PageBytes); fval[0] = 1;
          ready_q = 1;
        end
      end
      default: begin
        clear_pool();
        ready_q = 0;
      end
    endcase
    if (r.status != ST_OK) r.granted = '0;
    return r;
  endfunction

  // one item through the slave port; the prediction is queued at acceptance
  // tvalid stays high into the next call when no gap follows
  task automatic send_item(stim_t st);
    grant_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= st.cmd;
    s_axis_tdata_i  <= {7'b0, st.offset, st.size};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    p = pool_step(st.cmd, st.size, st.offset);
    if (st.has_want && p != st.want) begin
      errors++;
      if (errors <= 10)
        $display("predictor disagrees with table row: want %0d/%h got %0d/%h",
                 st.want.status, st.want.granted, p.status, p.granted);
    end
    if (st.cmd == CMD_ALLOC && p.status == ST_OK) live_q.push_back(p.granted);
    if (st.cmd == CMD_FREE && p.status == ST_OK)
      foreach (live_q[i]) if (live_q[i] == st.offset) begin
        live_q.delete(i);
        break;
      end
    if (st.cmd == CMD_RELEASE) live_q.delete();
    grant_q.push_back(p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_pages(logic [8:0] v);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pages_reg = v;
  endtask

  function automatic stim_t mk(cmd_e c, int sz, int off, bit hw = 0,
                               status_e ws = ST_OK, int wg = 0);
    stim_t s;
    s.cmd = c; s.size = 21'(sz); s.offset = 20'(off); s.has_want = hw;
    s.want.status = ws; s.want.granted = 20'(wg);
    return s;
  endfunction

  function automatic stim_t rand_item();
    stim_t s;
    int r;
    r = $urandom_range(0, 99);
    s = mk(CMD_ALLOC, 0, 0);
    s.size = 21'($urandom_range(0, 2097151));
    s.offset = 20'($urandom);
    if (r < 50) begin
      s.cmd = CMD_ALLOC;
      case ($urandom_range(0, 4))
        0: s.size = 21'($urandom_range(1, 64));
        1, 2: s.size = 21'($urandom_range(1, 16384));
        3: s.size = 21'($urandom_range(1, 1048576));
        default: ;
      endcase
    end else if (r < 88) begin
      s.cmd = CMD_FREE;
      if (live_q.size() != 0 && $urandom_range(0, 5) != 0)
        s.offset = live_q[$urandom_range(0, live_q.size() - 1)];
    end else if (r < 95) s.cmd = CMD_INIT;
    else s.cmd = CMD_RELEASE;
    return s;
  endfunction

  // result side: mostly short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_cnt != 0) begin
        stall_cnt--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 149) == 0) begin
        stall_cnt = $urandom_range(20, 120);
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) m_axis_tready_i <= 1'b0;
      else if ($urandom_range(0, 3) != 0) m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    grant_t w;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status %0d", m_axis_tuser_o);
      end else begin
        w = grant_q.pop_front();
        if (m_axis_tuser_o !== w.status || m_axis_tdata_o !== {4'b0, w.granted}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want status %0d offset %h, got status %0d offset %h",
                     w.status, w.granted, m_axis_tuser_o, m_axis_tdata_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  stim_t dir_tab[$];

  initial begin
    pages_reg = 9'd1;
    ready_q = 0;
    clear_pool();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tab = '{
      mk(CMD_ALLOC, 16, 0, 1, ST_NOT_READY, 0),
      mk(CMD_FREE, 0, 0, 1, ST_NOT_READY, 0),
      mk(CMD_RELEASE, 0, 0, 1, ST_OK, 0),
      mk(CMD_INIT, 0, 0, 1, ST_OK, 0),
      mk(CMD_ALLOC, 0, 0, 1, ST_ZERO_SIZE, 0),
      mk(CMD_ALLOC, 4097, 0, 1, ST_NO_FIT, 0),
      mk(CMD_ALLOC, 100, 0, 1, ST_OK, 0),
      mk(CMD_ALLOC, 3996, 0, 1, ST_OK, 100),
      mk(CMD_ALLOC, 1, 0, 1, ST_NO_FIT, 0),
      mk(CMD_FREE, 0, 7, 1, ST_BAD_ADDR, 0),
      mk(CMD_FREE, 0, 100),
      mk(CMD_FREE, 0, 0),
      mk(CMD_INIT, 0, 0, 1, ST_OK, 0),
      mk(CMD_ALLOC, 4096, 0, 1, ST_OK, 0),
      mk(CMD_FREE, 0, 0)
    };
    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // largest pool, full request, then table full via tiny allocs
    write_pages(9'd511);
    send_item(mk(CMD_RELEASE, 0, 0));
    send_item(mk(CMD_INIT, 0, 0));
    send_item(mk(CMD_ALLOC, 1048576, 0, 1, ST_OK, 0));
    send_item(mk(CMD_ALLOC, 1, 0, 1, ST_NO_FIT, 0));
    send_item(mk(CMD_FREE, 0, 0));
    for (int i = 0; i < 33; i++) send_item(mk(CMD_ALLOC, 8, 0));
    send_item(mk(CMD_FREE, 0, 20'hFFFFF));
    write_pages(9'd0);
    send_item(mk(CMD_RELEASE, 0, 0));
    send_item(mk(CMD_INIT, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_pages(9'd256);
        2: write_pages(9'd1);
        3: write_pages(9'($urandom_range(2, 300)));
        4: write_pages(9'd257);
        default: ;
      endcase
      if (ph != 0) begin
        send_item(mk(CMD_RELEASE, 0, 0));
        send_item(mk(CMD_INIT, 0, 0));
      end
      for (int i = 0; i < 160; i++) send_item(rand_item());
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
